FILE: hdl/bsc_pkg.sv
// Package for the backspace-edited string compare block.
// Holds the payload structs, command codes, sizes and controller interface types.
// No dependencies.
package bsc_pkg;

  localparam int STACK_DEPTH = 256;
  localparam int PTR_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int SYM_W       = 8;
  localparam int CMD_W       = 2;

  localparam logic [SYM_W-1:0] ERASE_RESET = 8'd35;

  localparam logic [CMD_W-1:0] CMD_FIRST   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SECOND  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_COMPARE = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [SYM_W-1:0] symbol;
  } in_data_t;

  typedef struct packed {
    logic strings_equal;
    logic overflowed;
  } out_data_t;

  typedef struct packed {
    logic push_first;
    logic push_second;
    logic start_cmp;
    logic walk;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic walk_done;
  } dp_sts_t;

endpackage

FILE: hdl/bsc_ctrl.sv
// Controller state machine for the backspace-edited string compare block.
// Drives the handshakes and the datapath commands; depends on bsc_pkg.
module bsc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  bsc_pkg::in_data_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output bsc_pkg::ctrl_cmd_t cmd,
  input  bsc_pkg::dp_sts_t   sts
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_WALK = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic accept;

  assign in_stall = (state_r == ST_WALK) ||
                    (out_valid_r && (in_data.command == bsc_pkg::CMD_COMPARE));
  assign accept   = in_valid && !in_stall;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt        = state_r;
    cmd.push_first   = 1'b0;
    cmd.push_second  = 1'b0;
    cmd.start_cmp    = 1'b0;
    cmd.walk         = 1'b0;
    cmd.load_out     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cmd.push_first  = (in_data.command == bsc_pkg::CMD_FIRST);
          cmd.push_second = (in_data.command == bsc_pkg::CMD_SECOND);
          if (in_data.command == bsc_pkg::CMD_COMPARE) begin
            cmd.start_cmp = 1'b1;
            state_nxt     = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        cmd.walk = 1'b1;
        if (sts.walk_done) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: hdl/bsc_dpath.sv
// Datapath for the backspace-edited string compare block.
// Holds both character stores, counts, overflow flag, compare walk and result register.
// Depends on bsc_pkg.
module bsc_dpath (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_wr_en,
  input  logic [bsc_pkg::SYM_W-1:0] cfg_wr_data,
  input  bsc_pkg::in_data_t        in_data,
  input  bsc_pkg::ctrl_cmd_t       cmd,
  output bsc_pkg::dp_sts_t         sts,
  output bsc_pkg::out_data_t       out_data
);

  localparam logic [bsc_pkg::CNT_W-1:0] DEPTH_CNT = bsc_pkg::CNT_W'(bsc_pkg::STACK_DEPTH);

  logic [bsc_pkg::SYM_W-1:0] first_mem  [bsc_pkg::STACK_DEPTH];
  logic [bsc_pkg::SYM_W-1:0] second_mem [bsc_pkg::STACK_DEPTH];

  logic [bsc_pkg::SYM_W-1:0] erase_r;
  logic [bsc_pkg::CNT_W-1:0] first_cnt_r, first_cnt_nxt;
  logic [bsc_pkg::CNT_W-1:0] second_cnt_r, second_cnt_nxt;
  logic                      ovf_r, ovf_nxt;
  logic [bsc_pkg::CNT_W-1:0] len_r;
  logic [bsc_pkg::CNT_W-1:0] idx_r;
  logic                      rd_vld_r;
  logic                      diff_r;
  logic [bsc_pkg::SYM_W-1:0] rd_first_r;
  logic [bsc_pkg::SYM_W-1:0] rd_second_r;
  bsc_pkg::out_data_t        out_r;

  logic is_erase;
  logic wr_first, wr_second;
  logic issue;

  assign is_erase = (in_data.symbol == erase_r);
  assign wr_first  = cmd.push_first  && !is_erase && (first_cnt_r  < DEPTH_CNT);
  assign wr_second = cmd.push_second && !is_erase && (second_cnt_r < DEPTH_CNT);
  assign issue     = cmd.walk && (idx_r != len_r);

  assign sts.walk_done = (idx_r == len_r) && !rd_vld_r;
  assign out_data      = out_r;

  always_comb begin
    first_cnt_nxt  = first_cnt_r;
    second_cnt_nxt = second_cnt_r;
    ovf_nxt        = ovf_r;
    if (cmd.push_first) begin
      if (is_erase) begin
        if (first_cnt_r != '0) first_cnt_nxt = first_cnt_r - 1'b1;
      end else if (first_cnt_r < DEPTH_CNT) begin
        first_cnt_nxt = first_cnt_r + 1'b1;
      end else begin
        ovf_nxt = 1'b1;
      end
    end
    if (cmd.push_second) begin
      if (is_erase) begin
        if (second_cnt_r != '0) second_cnt_nxt = second_cnt_r - 1'b1;
      end else if (second_cnt_r < DEPTH_CNT) begin
        second_cnt_nxt = second_cnt_r + 1'b1;
      end else begin
        ovf_nxt = 1'b1;
      end
    end
    if (cmd.start_cmp) begin
      first_cnt_nxt  = '0;
      second_cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      erase_r      <= bsc_pkg::ERASE_RESET;
      first_cnt_r  <= '0;
      second_cnt_r <= '0;
      ovf_r        <= 1'b0;
      idx_r        <= '0;
      len_r        <= '0;
      rd_vld_r     <= 1'b0;
      diff_r       <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        erase_r <= cfg_wr_data;
      end
      first_cnt_r  <= first_cnt_nxt;
      second_cnt_r <= second_cnt_nxt;
      ovf_r        <= ovf_nxt;
      rd_vld_r     <= issue;
      if (cmd.start_cmp) begin
        idx_r  <= '0;
        len_r  <= (first_cnt_r == second_cnt_r) ? first_cnt_r : '0;
        diff_r <= (first_cnt_r != second_cnt_r);
      end else begin
        if (issue) begin
          idx_r <= idx_r + 1'b1;
        end
        if (rd_vld_r && (rd_first_r != rd_second_r)) begin
          diff_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_first) begin
      first_mem[first_cnt_r[bsc_pkg::PTR_W-1:0]] <= in_data.symbol;
    end
    rd_first_r <= first_mem[idx_r[bsc_pkg::PTR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (wr_second) begin
      second_mem[second_cnt_r[bsc_pkg::PTR_W-1:0]] <= in_data.symbol;
    end
    rd_second_r <= second_mem[idx_r[bsc_pkg::PTR_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_r.strings_equal <= !diff_r;
      out_r.overflowed    <= ovf_r;
    end
  end

endmodule

FILE: hdl/backspace_edited_string_compare_top.sv
// Append transactions are accepted back to back outside a compare walk.
// A compare transaction walks both stores over their common length when both strings have
// equal length and over no entries otherwise, then presents its result; input stalls
// meanwhile, as both stores are read one entry per cycle. The next compare waits for the
// result to leave. Synchronous active-low reset empties both strings, clears the overflow
// flag and sets the erase code to 35; stored characters are not cleared.
module backspace_edited_string_compare_top (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_wr_en,
  input  logic [bsc_pkg::SYM_W-1:0] cfg_wr_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  bsc_pkg::in_data_t         in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output bsc_pkg::out_data_t        out_data
);

  bsc_pkg::ctrl_cmd_t cmd;
  bsc_pkg::dp_sts_t   sts;

  bsc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts)
  );

  bsc_dpath u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_data     (in_data),
    .cmd         (cmd),
    .sts         (sts),
    .out_data    (out_data)
  );

endmodule

FILE: hdl/bsc_checker.sv
// Port-level checker for the backspace-edited string compare block, with its bind.
// Depends on bsc_pkg and the top-level module.
module bsc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input bsc_pkg::in_data_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input bsc_pkg::out_data_t out_data
);

  logic cmp_accept;
  assign cmp_accept = in_valid && !in_stall && (in_data.command == bsc_pkg::CMD_COMPARE);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("Result transaction dropped while stalled.");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("Result payload changed while stalled.");

  a_cmp_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmp_accept |=> in_stall)
    else $error("Input not stalled during the compare walk.");

  a_cmp_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    cmp_accept |=> !out_valid)
    else $error("Result presented before the compare walk ran.");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("Result valid after reset.");

endmodule

bind backspace_edited_string_compare_top bsc_checker u_bsc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

FILE: tb/tb.sv
// Self-checking testbench for backspace_edited_string_compare_top.
// Drives edit and compare transactions, predicts every verdict and checks each result.
// Depends on bsc_pkg and the block's top level only.
`timescale 1ns / 1ps

module tb;

  localparam logic [bsc_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

  typedef logic [bsc_pkg::SYM_W-1:0] sym_q_t[$];
  typedef bsc_pkg::in_data_t key_q_t[$];

  class edit_tracker;
    logic [bsc_pkg::SYM_W-1:0] erase_code;
    logic [bsc_pkg::SYM_W-1:0] stacks [2][bsc_pkg::STACK_DEPTH];
    int                        lens [2];
    logic                      dropped_push;
    bsc_pkg::out_data_t        verdicts_due[$];
    int                        faults;

    function new();
      erase_code   = bsc_pkg::ERASE_RESET;
      lens[0]      = 0;
      lens[1]      = 0;
      dropped_push = 1'b0;
      faults       = 0;
    endfunction

    function void fault(string what);
      faults++;
      if (faults <= 10) $display("%0t ns: %s", $time, what);
    endfunction

    function void apply_edit(int side, logic [bsc_pkg::SYM_W-1:0] sym);
      if (sym == erase_code) begin
        if (lens[side] > 0) lens[side]--;
      end else if (lens[side] < bsc_pkg::STACK_DEPTH) begin
        stacks[side][lens[side]] = sym;
        lens[side]++;
      end else begin
        dropped_push = 1'b1;
      end
    endfunction

    function void note_item(bsc_pkg::in_data_t item);
      bsc_pkg::out_data_t v;
      case (item.command)
        bsc_pkg::CMD_FIRST: apply_edit(0, item.symbol);
        bsc_pkg::CMD_SECOND: apply_edit(1, item.symbol);
        bsc_pkg::CMD_COMPARE: begin
          v.strings_equal = (lens[0] == lens[1]);
          for (int i = 0; i < lens[0] && v.strings_equal; i++) begin
            if (stacks[0][i] != stacks[1][i]) v.strings_equal = 1'b0;
          end
          v.overflowed = dropped_push;
          verdicts_due.push_back(v);
          lens[0] = 0;
          lens[1] = 0;
        end
        default: ;
      endcase
    endfunction

    function void check_verdict(bsc_pkg::out_data_t got);
      bsc_pkg::out_data_t want;
      if (verdicts_due.size() == 0) begin
        fault($sformatf("unexpected result equal=%0b overflow=%0b",
                        got.strings_equal, got.overflowed));
        return;
      end
      want = verdicts_due.pop_front();
      if (got.strings_equal !== want.strings_equal)
        fault($sformatf("strings_equal expected %0b got %0b",
                        want.strings_equal, got.strings_equal));
      if (got.overflowed !== want.overflowed)
        fault($sformatf("overflowed expected %0b got %0b",
                        want.overflowed, got.overflowed));
    endfunction

    function void wrap_up();
      if (verdicts_due.size() != 0)
        fault($sformatf("%0d results never arrived", verdicts_due.size()));
    endfunction
  endclass

  logic                      clk;
  logic                      rst_n;
  logic                      cfg_wr_en;
  logic [bsc_pkg::SYM_W-1:0] cfg_wr_data;
  logic                      in_valid;
  logic                      in_stall;
  bsc_pkg::in_data_t         in_data;
  logic                      out_valid;
  logic                      out_stall;
  bsc_pkg::out_data_t        out_data;

  edit_tracker book = new();
  bit lazy;
  int items_sent;

  backspace_edited_string_compare_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) book.note_item(in_data);
      if (out_valid && !out_stall) book.check_verdict(out_data);
    end
  end

  always @(negedge clk) begin
    out_stall <= lazy && ($urandom_range(0, 99) < 28);
  end

  function automatic logic [bsc_pkg::SYM_W-1:0] pick_plain();
    logic [bsc_pkg::SYM_W-1:0] s;
    s = bsc_pkg::SYM_W'($urandom_range(0, 255));
    if (s == book.erase_code) s = s ^ 8'h01;
    return s;
  endfunction

  task automatic send_item(logic [bsc_pkg::CMD_W-1:0] cmd, logic [bsc_pkg::SYM_W-1:0] sym);
    @(negedge clk);
    while (lazy && $urandom_range(0, 99) < 28) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_data.command <= cmd;
    in_data.symbol  <= sym;
    do @(posedge clk); while (in_stall);
    items_sent++;
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (book.verdicts_due.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_erase(logic [bsc_pkg::SYM_W-1:0] code);
    @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= code;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    book.erase_code = code;
  endtask

  function automatic key_q_t keystrokes(logic [bsc_pkg::CMD_W-1:0] cmd, sym_q_t text);
    key_q_t ks;
    bsc_pkg::in_data_t k;
    k.command = cmd;
    if ($urandom_range(0, 9) == 0) begin
      k.symbol = book.erase_code;
      ks.push_back(k);
    end
    foreach (text[i]) begin
      if ($urandom_range(0, 99) < 15) begin
        k.symbol = pick_plain();
        ks.push_back(k);
        k.symbol = book.erase_code;
        ks.push_back(k);
      end
      k.symbol = text[i];
      ks.push_back(k);
    end
    return ks;
  endfunction

  task automatic run_pairs(int budget);
    int stop;
    int len;
    int idx;
    sym_q_t left_text;
    sym_q_t right_text;
    key_q_t left_keys;
    key_q_t right_keys;
    bsc_pkg::in_data_t key;
    stop = items_sent + budget;
    while (items_sent < stop) begin
      if ($urandom_range(0, 99) < 15) begin
        // Noise: any command, often the erase code.
        repeat ($urandom_range(1, 8)) begin
          send_item(bsc_pkg::CMD_W'($urandom_range(0, 3)),
                    ($urandom_range(0, 3) == 0) ? book.erase_code :
                                                  bsc_pkg::SYM_W'($urandom_range(0, 255)));
        end
        continue;
      end
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 6);
      left_text.delete();
      repeat (len) left_text.push_back(pick_plain());
      right_text = left_text;
      case ($urandom_range(0, 9))
        0, 1: begin
          if (right_text.size() > 0) begin
            idx = $urandom_range(0, right_text.size() - 1);
            do right_text[idx] = pick_plain(); while (right_text[idx] == left_text[idx]);
          end
        end
        2: if (right_text.size() > 0) void'(right_text.pop_back());
        3: right_text.push_back(pick_plain());
        default: ;
      endcase
      left_keys  = keystrokes(bsc_pkg::CMD_FIRST, left_text);
      right_keys = keystrokes(bsc_pkg::CMD_SECOND, right_text);
      while (left_keys.size() != 0 || right_keys.size() != 0) begin
        if ($urandom_range(0, 99) < 5)
          send_item(CMD_UNUSED, bsc_pkg::SYM_W'($urandom_range(0, 255)));
        if (left_keys.size() != 0 && (right_keys.size() == 0 || $urandom_range(0, 1)))
          key = left_keys.pop_front();
        else
          key = right_keys.pop_front();
        send_item(key.command, key.symbol);
      end
      if ($urandom_range(0, 9) != 0)
        send_item(bsc_pkg::CMD_COMPARE, bsc_pkg::SYM_W'($urandom_range(0, 255)));
    end
  endtask

  task automatic fill_to_brim();
    sym_q_t text;
    repeat (bsc_pkg::STACK_DEPTH) text.push_back(pick_plain());
    send_item(bsc_pkg::CMD_COMPARE, 8'h00);
    foreach (text[i]) send_item(bsc_pkg::CMD_FIRST, text[i]);
    send_item(bsc_pkg::CMD_FIRST, pick_plain());
    send_item(bsc_pkg::CMD_FIRST, pick_plain());
    foreach (text[i]) send_item(bsc_pkg::CMD_SECOND, text[i]);
    send_item(bsc_pkg::CMD_COMPARE, 8'hFF);
  endtask

  initial begin
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_valid    = 1'b0;
    in_data     = '0;
    lazy        = 1'b1;
    items_sent  = 0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    send_item(bsc_pkg::CMD_FIRST, bsc_pkg::ERASE_RESET);
    send_item(bsc_pkg::CMD_SECOND, bsc_pkg::ERASE_RESET);
    send_item(bsc_pkg::CMD_COMPARE, 8'hFF);
    send_item(bsc_pkg::CMD_FIRST, 8'h00);
    send_item(bsc_pkg::CMD_FIRST, 8'hFF);
    send_item(bsc_pkg::CMD_SECOND, 8'h00);
    send_item(bsc_pkg::CMD_SECOND, 8'hFF);
    send_item(CMD_UNUSED, 8'h12);
    send_item(bsc_pkg::CMD_COMPARE, 8'h00);
    send_item(bsc_pkg::CMD_FIRST, "x");
    send_item(bsc_pkg::CMD_FIRST, bsc_pkg::ERASE_RESET);
    send_item(bsc_pkg::CMD_FIRST, "y");
    send_item(bsc_pkg::CMD_SECOND, "y");
    send_item(bsc_pkg::CMD_COMPARE, bsc_pkg::ERASE_RESET);
    send_item(bsc_pkg::CMD_FIRST, "a");
    send_item(bsc_pkg::CMD_SECOND, "b");
    send_item(bsc_pkg::CMD_COMPARE, 8'h5A);
    send_item(bsc_pkg::CMD_FIRST, "a");
    send_item(bsc_pkg::CMD_FIRST, "b");
    send_item(bsc_pkg::CMD_SECOND, "a");
    send_item(bsc_pkg::CMD_COMPARE, 8'hA5);
    send_item(CMD_UNUSED, bsc_pkg::ERASE_RESET);
    send_item(bsc_pkg::CMD_COMPARE, 8'h00);

    run_pairs(180);
    settle();
    write_erase(8'h00);
    run_pairs(180);
    settle();
    lazy = 1'b0;
    write_erase(8'hFF);
    run_pairs(180);
    settle();
    lazy = 1'b1;
    write_erase(bsc_pkg::SYM_W'($urandom_range(1, 254)));
    run_pairs(180);
    settle();
    write_erase(bsc_pkg::SYM_W'($urandom_range(0, 255)));
    fill_to_brim();
    run_pairs(80);
    settle();

    book.wrap_up();
    if (book.faults == 0) begin
      $display("backspace_edited_string_compare_top: match");
    end else begin
      $display("backspace_edited_string_compare_top: mismatch");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("backspace_edited_string_compare_top: mismatch");
    $finish;
  end

endmodule

FILE: files.f
hdl/bsc_pkg.sv
hdl/bsc_ctrl.sv
hdl/bsc_dpath.sv
hdl/backspace_edited_string_compare_top.sv
hdl/bsc_checker.sv
tb/tb.sv
